### hw/rtl/lbpc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lbpc_pkg
// shared types, codes and reset constants of the led blink pattern controller
// ----------------------------------------------------------------------------
package lbpc_pkg;

    localparam int LED_COUNT = 8;
    localparam int MASK_W    = 8;
    localparam int OP_W      = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 8;
    localparam int TICK_W    = 8;
    localparam int PHASE_W   = 2;

    // positions that exist
    localparam logic [MASK_W-1:0] LED_ALL = MASK_W'((64'd1 << LED_COUNT) - 64'd1);

    // register reset values
    localparam logic [TICK_W-1:0] SLOW_PERIOD_RST = TICK_W'(70);
    localparam logic [TICK_W-1:0] FAST_PERIOD_RST = TICK_W'(20);
    localparam logic [TICK_W-1:0] BEAT_ONE_RST    = TICK_W'(10);
    localparam logic [TICK_W-1:0] BEAT_TWO_RST    = TICK_W'(20);
    localparam logic [TICK_W-1:0] BEAT_THREE_RST  = TICK_W'(10);
    localparam logic [TICK_W-1:0] BEAT_FOUR_RST   = TICK_W'(120);

    typedef enum logic [OP_W-1:0] {
        OP_TICK = 3'd0,
        OP_OFF  = 3'd1,
        OP_ON   = 3'd2,
        OP_SLOW = 3'd3,
        OP_FAST = 3'd4,
        OP_BEAT = 3'd5
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ATTACHED    = 3'd0,
        REG_ACTIVE_HIGH = 3'd1,
        REG_SLOW_PERIOD = 3'd2,
        REG_FAST_PERIOD = 3'd3,
        REG_BEAT_ONE    = 3'd4,
        REG_BEAT_TWO    = 3'd5,
        REG_BEAT_THREE  = 3'd6,
        REG_BEAT_FOUR   = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [MASK_W-1:0] led_mask;
    } cmd_item_t;

    typedef struct packed {
        logic [MASK_W-1:0] pin_levels;
        logic [MASK_W-1:0] lit_bits;
    } res_item_t;

    typedef struct packed {
        logic [MASK_W-1:0]             attached;
        logic [MASK_W-1:0]             active_high;
        logic [TICK_W-1:0]             slow_period;
        logic [TICK_W-1:0]             fast_period;
        logic [3:0][TICK_W-1:0]        beat_load;
    } cfg_t;

endpackage
`default_nettype wire

### hw/rtl/lbpc_cfg_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lbpc_cfg_regs
// configuration register file, written through a plain write port
// ----------------------------------------------------------------------------
module lbpc_cfg_regs (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [lbpc_pkg::CFG_IDX_W-1:0] cfg_idx,
    input  wire logic [lbpc_pkg::CFG_W-1:0]     cfg_wdata,
    output lbpc_pkg::cfg_t                      cfg
);

    lbpc_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.attached     <= '0;
            cfg_reg.active_high  <= '0;
            cfg_reg.slow_period  <= lbpc_pkg::SLOW_PERIOD_RST;
            cfg_reg.fast_period  <= lbpc_pkg::FAST_PERIOD_RST;
            cfg_reg.beat_load[0] <= lbpc_pkg::BEAT_ONE_RST;
            cfg_reg.beat_load[1] <= lbpc_pkg::BEAT_TWO_RST;
            cfg_reg.beat_load[2] <= lbpc_pkg::BEAT_THREE_RST;
            cfg_reg.beat_load[3] <= lbpc_pkg::BEAT_FOUR_RST;
        end
        else if (cfg_we)
        begin
            case (lbpc_pkg::reg_idx_t'(cfg_idx))
                lbpc_pkg::REG_ATTACHED:    cfg_reg.attached    <= cfg_wdata & lbpc_pkg::LED_ALL;
                lbpc_pkg::REG_ACTIVE_HIGH: cfg_reg.active_high <= cfg_wdata & lbpc_pkg::LED_ALL;
                lbpc_pkg::REG_SLOW_PERIOD: cfg_reg.slow_period <= cfg_wdata;
                lbpc_pkg::REG_FAST_PERIOD: cfg_reg.fast_period <= cfg_wdata;
                lbpc_pkg::REG_BEAT_ONE:    cfg_reg.beat_load[0] <= cfg_wdata;
                lbpc_pkg::REG_BEAT_TWO:    cfg_reg.beat_load[1] <= cfg_wdata;
                lbpc_pkg::REG_BEAT_THREE:  cfg_reg.beat_load[2] <= cfg_wdata;
                lbpc_pkg::REG_BEAT_FOUR:   cfg_reg.beat_load[3] <= cfg_wdata;
                default:                   cfg_reg.attached    <= cfg_reg.attached;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

### hw/rtl/lbpc_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lbpc_core
// led mode sets, tick counters and pin latch, one item per step
// ----------------------------------------------------------------------------
module lbpc_core (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 step,
    input  wire lbpc_pkg::cmd_item_t  item,
    input  wire lbpc_pkg::cfg_t       cfg,
    output lbpc_pkg::res_item_t       result_next
);

    localparam int MW = lbpc_pkg::MASK_W;
    localparam int TW = lbpc_pkg::TICK_W;

    typedef struct packed {
        logic [MW-1:0] lit;
        logic [MW-1:0] pin;
    } led_drv_t;

    logic [MW-1:0] lit_reg, steady_reg, slow_set_reg, fast_set_reg, beat_set_reg, pin_reg;
    logic [MW-1:0] lit_next, steady_next, slow_set_next, fast_set_next, beat_set_next, pin_next;
    logic [TW-1:0] slow_ticks_reg, fast_ticks_reg, beat_ticks_reg;
    logic [TW-1:0] slow_ticks_next, fast_ticks_next, beat_ticks_next;
    logic [lbpc_pkg::PHASE_W-1:0] beat_phase_reg, beat_phase_next;
    logic [MW-1:0] mask;
    led_drv_t      drv;

    function automatic logic [MW-1:0] drive_pins(
        input logic [MW-1:0] levels,
        input logic [MW-1:0] pin,
        input logic [MW-1:0] att,
        input logic [MW-1:0] ah
    );
        logic [MW-1:0] want;
        want = (levels ^ ~ah) & att & lbpc_pkg::LED_ALL;
        return (want | (pin & ~att)) & lbpc_pkg::LED_ALL;
    endfunction

    function automatic led_drv_t turn_on(
        input logic [MW-1:0] m,
        input led_drv_t      cur,
        input logic [MW-1:0] att,
        input logic [MW-1:0] ah
    );
        led_drv_t      res;
        logic [MW-1:0] readback;
        readback = cur.pin & att & ah;
        res.lit  = (cur.lit | m) & lbpc_pkg::LED_ALL;
        res.pin  = drive_pins(readback | res.lit, cur.pin, att, ah);
        return res;
    endfunction

    function automatic led_drv_t turn_off(
        input logic [MW-1:0] m,
        input led_drv_t      cur,
        input logic [MW-1:0] att,
        input logic [MW-1:0] ah
    );
        led_drv_t res;
        res.lit = cur.lit & ~m;
        res.pin = drive_pins(res.lit, cur.pin, att, ah);
        return res;
    endfunction

    // all on unless already all on, then all off
    function automatic led_drv_t reverse(
        input logic [MW-1:0] m,
        input led_drv_t      cur,
        input logic [MW-1:0] att,
        input logic [MW-1:0] ah
    );
        led_drv_t res;
        res = cur;
        if (m != '0)
        begin
            res = turn_on(m, cur, att, ah);
            if (res.lit == cur.lit)
            begin
                res = turn_off(m, res, att, ah);
            end
        end
        return res;
    endfunction

    always_comb
    begin
        mask            = item.led_mask & lbpc_pkg::LED_ALL;
        drv.lit         = lit_reg;
        drv.pin         = pin_reg;
        steady_next     = steady_reg;
        slow_set_next   = slow_set_reg;
        fast_set_next   = fast_set_reg;
        beat_set_next   = beat_set_reg;
        slow_ticks_next = slow_ticks_reg;
        fast_ticks_next = fast_ticks_reg;
        beat_ticks_next = beat_ticks_reg;
        beat_phase_next = beat_phase_reg;

        case (lbpc_pkg::op_t'(item.operation))
            lbpc_pkg::OP_TICK:
            begin
                // slow, then fast, then heartbeat, each on the state left before
                slow_ticks_next = slow_ticks_reg + TW'(1);
                fast_ticks_next = fast_ticks_reg + TW'(1);
                beat_ticks_next = beat_ticks_reg - TW'(1);
                if (slow_ticks_next == cfg.slow_period)
                begin
                    drv             = reverse(slow_set_reg, drv, cfg.attached, cfg.active_high);
                    slow_ticks_next = '0;
                end
                if (fast_ticks_next == cfg.fast_period)
                begin
                    drv             = reverse(fast_set_reg, drv, cfg.attached, cfg.active_high);
                    fast_ticks_next = '0;
                end
                if (beat_ticks_next == '0)
                begin
                    beat_ticks_next = cfg.beat_load[beat_phase_reg];
                    beat_phase_next = beat_phase_reg + lbpc_pkg::PHASE_W'(1);
                    drv             = reverse(beat_set_reg, drv, cfg.attached, cfg.active_high);
                end
            end
            lbpc_pkg::OP_OFF:
            begin
                steady_next   = steady_reg & ~mask;
                slow_set_next = slow_set_reg & ~mask;
                fast_set_next = fast_set_reg & ~mask;
                beat_set_next = beat_set_reg & ~mask;
                drv           = turn_off(mask, drv, cfg.attached, cfg.active_high);
            end
            lbpc_pkg::OP_ON:
            begin
                steady_next   = steady_reg | mask;
                slow_set_next = slow_set_reg & ~mask;
                fast_set_next = fast_set_reg & ~mask;
                beat_set_next = beat_set_reg & ~mask;
                drv           = turn_on(steady_next, drv, cfg.attached, cfg.active_high);
            end
            lbpc_pkg::OP_SLOW:
            begin
                steady_next   = steady_reg & ~mask;
                slow_set_next = slow_set_reg | mask;
                fast_set_next = fast_set_reg & ~mask;
                beat_set_next = beat_set_reg & ~mask;
            end
            lbpc_pkg::OP_FAST:
            begin
                steady_next   = steady_reg & ~mask;
                slow_set_next = slow_set_reg & ~mask;
                fast_set_next = fast_set_reg | mask;
                beat_set_next = beat_set_reg & ~mask;
            end
            lbpc_pkg::OP_BEAT:
            begin
                slow_set_next = slow_set_reg & ~mask;
                fast_set_next = fast_set_reg & ~mask;
                beat_set_next = beat_set_reg | mask;
            end
            default:
            begin
                // unused codes leave the state alone
                drv.lit = lit_reg;
            end
        endcase

        lit_next = drv.lit;
        pin_next = drv.pin;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lit_reg        <= '0;
            steady_reg     <= '0;
            slow_set_reg   <= '0;
            fast_set_reg   <= '0;
            beat_set_reg   <= '0;
            pin_reg        <= '0;
            slow_ticks_reg <= '0;
            fast_ticks_reg <= '0;
            beat_ticks_reg <= TW'(1);
            beat_phase_reg <= '0;
        end
        else if (step)
        begin
            lit_reg        <= lit_next;
            steady_reg     <= steady_next;
            slow_set_reg   <= slow_set_next;
            fast_set_reg   <= fast_set_next;
            beat_set_reg   <= beat_set_next;
            pin_reg        <= pin_next;
            slow_ticks_reg <= slow_ticks_next;
            fast_ticks_reg <= fast_ticks_next;
            beat_ticks_reg <= beat_ticks_next;
            beat_phase_reg <= beat_phase_next;
        end
    end

    assign result_next.pin_levels = pin_next;
    assign result_next.lit_bits   = lit_next;

    // blink groups never share an led
    a_groups_disjoint: assert property (@(posedge clk) disable iff (!rst_n)
        ((slow_set_reg & fast_set_reg) | (slow_set_reg & beat_set_reg)
         | (fast_set_reg & beat_set_reg)) == '0)
        else $error("blink groups overlap");

    // unattached pins keep their latch across a step
    a_unattached_hold: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> ((pin_reg & ~$past(cfg.attached)) == ($past(pin_reg) & ~$past(cfg.attached))))
        else $error("unattached pin changed");

    // led state moves only on a step
    a_lit_only_on_step: assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> $stable(lit_reg) && $stable(pin_reg))
        else $error("led state changed without a step");

endmodule
`default_nettype wire

### hw/rtl/led_blink_pattern_controller_top.sv
`default_nettype none
// a command beat is captured in the input register, then processed into the result register once that slot is free
// throughput: one beat per cycle, limited only by result stall
// the input register and the result register each hold one beat, so a new
// command is taken while a finished result still waits downstream
// reset: asynchronous active-low rst_n empties both registers, clears all led
// state and loads the default periods; heartbeat counter resets to one
// ----------------------------------------------------------------------------
// led_blink_pattern_controller_top
// eight-led blink pattern controller with command and result beat channels
// ----------------------------------------------------------------------------
module led_blink_pattern_controller_top (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // command channel
    input  wire logic                           cmd_valid,
    output logic                                cmd_stall,
    input  wire lbpc_pkg::cmd_item_t            cmd_item,
    // result channel
    output logic                                res_valid,
    input  wire logic                           res_stall,
    output lbpc_pkg::res_item_t                 res_item,
    // configuration write port
    input  wire logic                           cfg_we,
    input  wire logic [lbpc_pkg::CFG_IDX_W-1:0] cfg_idx,
    input  wire logic [lbpc_pkg::CFG_W-1:0]     cfg_wdata
);

    lbpc_pkg::cfg_t      cfg;
    lbpc_pkg::cmd_item_t cmd_item_reg;
    lbpc_pkg::res_item_t res_item_reg;
    lbpc_pkg::res_item_t result_next;
    logic                cmd_valid_reg;
    logic                res_valid_reg;
    logic                advance;
    logic                step;
    logic                cmd_take;

    // result slot is free or being emptied this cycle
    assign advance   = !res_valid_reg || !res_stall;
    // staged command is processed into the result register
    assign step      = cmd_valid_reg && advance;
    // input register holds a beat that cannot move on
    assign cmd_stall = cmd_valid_reg && !advance;
    assign cmd_take  = cmd_valid && !cmd_stall;

    lbpc_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    lbpc_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .item        (cmd_item_reg),
        .cfg         (cfg),
        .result_next (result_next)
    );

    // valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd_take)
            begin
                cmd_valid_reg <= 1'b1;
            end
            else if (step)
            begin
                cmd_valid_reg <= 1'b0;
            end

            if (step)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (cmd_take)
        begin
            cmd_item_reg <= cmd_item;
        end
        if (step)
        begin
            res_item_reg <= result_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_item  = res_item_reg;

    // a processed command always leaves a result beat
    a_step_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> res_valid_reg)
        else $error("processed command lost its result");

    // a stalled result beat is never overwritten
    a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_stall) |-> !step)
        else $error("result overwritten while stalled");

    // a new result beat only follows a staged command
    a_result_from_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(cmd_valid_reg))
        else $error("result beat without a command");

endmodule
`default_nettype wire
